### rtl/clock_calendar_counter_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the clock calendar counter
// Shared property templates: same-cycle and next-cycle implications, both
// clocked on the rising edge and disabled while reset is held.
// ----------------------------------------------------------------------------
`ifndef CLOCK_CALENDAR_COUNTER_TOP_MACROS_SVH
`define CLOCK_CALENDAR_COUNTER_TOP_MACROS_SVH

// check cons in the cycle where ante holds
`define CCC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// check cons in the cycle after ante holds
`define CCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ccc_pkg.sv
// ----------------------------------------------------------------------------
// Clock calendar counter package
// Commands, field codes, time record types, reset values and the calendar
// helper functions (leap-year test and month length).
// ----------------------------------------------------------------------------
package ccc_pkg;

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_LOAD = 2'd1,
        CMD_UP   = 2'd2,
        CMD_DOWN = 2'd3
    } t_cmd;

    localparam logic [2:0] FLD_SEC   = 3'd0;
    localparam logic [2:0] FLD_MIN   = 3'd1;
    localparam logic [2:0] FLD_HOUR  = 3'd2;
    localparam logic [2:0] FLD_DAY   = 3'd3;
    localparam logic [2:0] FLD_MONTH = 3'd4;
    localparam logic [2:0] FLD_YEAR  = 3'd5;

    localparam logic [3:0] MON_JAN = 4'd1;
    localparam logic [3:0] MON_FEB = 4'd2;
    localparam logic [3:0] MON_APR = 4'd4;
    localparam logic [3:0] MON_JUN = 4'd6;
    localparam logic [3:0] MON_SEP = 4'd9;
    localparam logic [3:0] MON_NOV = 4'd11;
    localparam logic [3:0] MON_DEC = 4'd12;

    localparam logic [5:0]  SEC_MAX  = 6'd59;
    localparam logic [5:0]  MIN_MAX  = 6'd59;
    localparam logic [4:0]  HOUR_MAX = 5'd23;
    localparam logic [4:0]  DAY_MIN  = 5'd1;
    localparam logic [13:0] YEAR_MIN = 14'd0;
    localparam logic [13:0] YEAR_MAX = 14'd9999;

    localparam logic [4:0] LEN_31 = 5'd31;
    localparam logic [4:0] LEN_30 = 5'd30;
    localparam logic [4:0] LEN_29 = 5'd29;
    localparam logic [4:0] LEN_28 = 5'd28;

    // multiplicative inverse of 25 modulo 2**14 and the divisibility bound
    localparam logic [13:0] INV25       = 14'd7209;
    localparam logic [13:0] DIV25_LIMIT = 14'd655;

    localparam logic [15:0] RST_TPS  = 16'd200;
    localparam logic [13:0] RST_YEAR = 14'd2000;

    typedef struct packed {
        logic [5:0]  sec;
        logic [5:0]  min;
        logic [4:0]  hour;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
    } t_time;

    localparam t_time RST_TIME = '{
        sec:   6'd0,
        min:   6'd0,
        hour:  5'd0,
        day:   DAY_MIN,
        month: MON_JAN,
        year:  RST_YEAR
    };

    typedef struct packed {
        t_cmd       cmd;
        logic [2:0] sel;
        t_time      load;
        logic       load_leap;
    } t_item;

    typedef struct packed {
        t_time       tm;
        logic [15:0] prescale;
        logic        strobe;
    } t_next;

    typedef struct packed {
        t_time tm;
        logic  strobe;
    } t_result;

    // leap: divisible by 4, and not by 100 unless by 400
    function automatic logic is_leap(input logic [13:0] yr);
        logic [27:0] prod;
        logic        div25;
        prod  = yr * INV25;
        div25 = (prod[13:0] <= DIV25_LIMIT);
        return (yr[1:0] == 2'b00) && (!div25 || (yr[3:0] == 4'b0000));
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] mth, input logic leap);
        logic [4:0] len;
        case (mth) inside
            MON_APR, MON_JUN, MON_SEP, MON_NOV: len = LEN_30;
            MON_FEB: len = leap ? LEN_29 : LEN_28;
            default: len = LEN_31;
        endcase
        return len;
    endfunction

endpackage

### rtl/ccc_in_if.sv
// ----------------------------------------------------------------------------
// Clock calendar counter input channel
// Valid/ready channel carrying one command item.
// ----------------------------------------------------------------------------
interface ccc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [2:0]  field_select;
    logic [5:0]  new_second;
    logic [5:0]  new_minute;
    logic [4:0]  new_hour;
    logic [4:0]  new_day;
    logic [3:0]  new_month;
    logic [13:0] new_year;

    modport source (
        output valid, cmd, field_select, new_second, new_minute, new_hour,
               new_day, new_month, new_year,
        input  ready
    );

    modport sink (
        input  valid, cmd, field_select, new_second, new_minute, new_hour,
               new_day, new_month, new_year,
        output ready
    );
endinterface

### rtl/ccc_out_if.sv
// ----------------------------------------------------------------------------
// Clock calendar counter result channel
// Valid/ready channel carrying the time and date after each item.
// ----------------------------------------------------------------------------
interface ccc_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  cur_second;
    logic [5:0]  cur_minute;
    logic [4:0]  cur_hour;
    logic [4:0]  cur_day;
    logic [3:0]  cur_month;
    logic [13:0] cur_year;
    logic        second_strobe;

    modport source (
        output valid, cur_second, cur_minute, cur_hour, cur_day, cur_month,
               cur_year, second_strobe,
        input  ready
    );

    modport sink (
        input  valid, cur_second, cur_minute, cur_hour, cur_day, cur_month,
               cur_year, second_strobe,
        output ready
    );
endinterface

### rtl/clock_calendar_counter_top.sv
// ----------------------------------------------------------------------------
// Clock calendar counter top level
// Real-time clock with Gregorian calendar: prescaled seconds, cascade to the
// year, field load and field stepping, one result item per command item.
// ----------------------------------------------------------------------------
// One item is taken every clock cycle when the result side keeps up. Each
// item passes an input register, where load values are clamped and the leap
// flag of the loaded year is formed, and then one pass of next-state logic
// into the calendar registers and the result register. The seconds advance
// on the tick item that finds the prescaler at 0 or 1; the leap test is one
// constant multiply by the inverse of 25 plus low-bit checks. A write on the
// configuration port sets the ticks-per-second reload value and takes effect
// at the next reload; it must only be issued while no item is in flight.
// ----------------------------------------------------------------------------
`include "clock_calendar_counter_top_macros.svh"

module clock_calendar_counter_top
    import ccc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    ccc_in_if.sink      i_item,
    ccc_out_if.source   o_result
);

    logic        r_in_valid;
    t_item       r_item;
    t_item       n_item;
    logic        r_out_valid;
    t_result     r_out;
    t_time       r_time;
    logic [15:0] r_prescale;
    logic [15:0] r_tps;
    t_next       n_state;
    logic        in_accept;
    logic        core_fire;
    logic [13:0] load_year;

    assign core_fire     = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready  = !r_in_valid || core_fire;
    assign in_accept     = i_item.valid && i_item.ready;

    // clamp load values other than the day on entry
    always_comb begin
        load_year           = (i_item.new_year > YEAR_MAX) ? YEAR_MAX : i_item.new_year;
        n_item.cmd          = t_cmd'(i_item.cmd);
        n_item.sel          = i_item.field_select;
        n_item.load.sec     = (i_item.new_second > SEC_MAX) ? SEC_MAX : i_item.new_second;
        n_item.load.min     = (i_item.new_minute > MIN_MAX) ? MIN_MAX : i_item.new_minute;
        n_item.load.hour    = (i_item.new_hour > HOUR_MAX) ? HOUR_MAX : i_item.new_hour;
        n_item.load.day     = i_item.new_day;
        n_item.load.month   = (i_item.new_month > MON_DEC) ? MON_DEC :
                              (i_item.new_month < MON_JAN) ? MON_JAN : i_item.new_month;
        n_item.load.year    = load_year;
        n_item.load_leap    = is_leap(load_year);
    end

    ccc_calendar_next u_next (
        .i_cur      (r_time),
        .i_prescale (r_prescale),
        .i_tps      (r_tps),
        .i_item     (r_item),
        .o_next     (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_tps       <= RST_TPS;
            r_prescale  <= RST_TPS;
            r_time      <= RST_TIME;
        end else begin
            if (i_cfg_wr_en) begin
                r_tps <= i_cfg_wr_data;
            end
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (core_fire) begin
                r_in_valid <= 1'b0;
            end
            if (core_fire) begin
                r_time      <= n_state.tm;
                r_prescale  <= n_state.prescale;
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item <= n_item;
        end
        if (core_fire) begin
            r_out.tm     <= n_state.tm;
            r_out.strobe <= n_state.strobe;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.cur_second    = r_out.tm.sec;
    assign o_result.cur_minute    = r_out.tm.min;
    assign o_result.cur_hour      = r_out.tm.hour;
    assign o_result.cur_day       = r_out.tm.day;
    assign o_result.cur_month     = r_out.tm.month;
    assign o_result.cur_year      = r_out.tm.year;
    assign o_result.second_strobe = r_out.strobe;

    `CCC_ASSERT_SAME(a_result_legal, i_clk, i_rst_n, o_result.valid,
        (r_out.tm.sec <= SEC_MAX) && (r_out.tm.min <= MIN_MAX) &&
        (r_out.tm.hour <= HOUR_MAX) && (r_out.tm.day >= DAY_MIN) &&
        (r_out.tm.month >= MON_JAN) && (r_out.tm.month <= MON_DEC) &&
        (r_out.tm.year <= YEAR_MAX), "result item holds an illegal time or date")
    `CCC_ASSERT_NEXT(a_strobe_reload, i_clk, i_rst_n,
        core_fire && n_state.strobe && !i_cfg_wr_en,
        r_prescale == $past(r_tps), "seconds advanced without prescaler reload")
    `CCC_ASSERT_NEXT(a_no_tick_prescale, i_clk, i_rst_n,
        core_fire && (r_item.cmd != CMD_TICK),
        $stable(r_prescale), "non-tick item moved the prescaler")
    `CCC_ASSERT_NEXT(a_input_held, i_clk, i_rst_n, r_in_valid && !core_fire,
        r_in_valid && $stable(r_item), "stalled item lost from input register")

endmodule

### rtl/ccc_calendar_next.sv
// ----------------------------------------------------------------------------
// Clock calendar next-state logic
// Prescaler, seconds-to-year cascade, field load with clamping and single
// field stepping, for one registered item against the current time.
// ----------------------------------------------------------------------------
module ccc_calendar_next
    import ccc_pkg::*;
(
    input  t_time       i_cur,
    input  logic [15:0] i_prescale,
    input  logic [15:0] i_tps,
    input  t_item       i_item,
    output t_next       o_next
);

    logic       cur_leap;
    logic [4:0] cur_len;
    logic [4:0] load_len;
    logic [4:0] load_day;
    logic       step_up;
    t_next      nxt;

    always_comb begin
        cur_leap = is_leap(i_cur.year);
        cur_len  = month_len(i_cur.month, cur_leap);
        load_len = month_len(i_item.load.month, i_item.load_leap);
        load_day = (i_item.load.day > load_len) ? load_len : i_item.load.day;
        step_up  = (i_item.cmd == CMD_UP);

        nxt.tm       = i_cur;
        nxt.prescale = i_prescale;
        nxt.strobe   = 1'b0;

        unique case (i_item.cmd)
            CMD_TICK: begin
                if (i_prescale <= 16'd1) begin
                    nxt.prescale = i_tps;
                    nxt.strobe   = 1'b1;
                    if (i_cur.sec >= SEC_MAX) begin
                        nxt.tm.sec = 6'd0;
                        if (i_cur.min >= MIN_MAX) begin
                            nxt.tm.min = 6'd0;
                            if (i_cur.hour >= HOUR_MAX) begin
                                nxt.tm.hour = 5'd0;
                                if (i_cur.day >= cur_len) begin
                                    nxt.tm.day = DAY_MIN;
                                    if (i_cur.month >= MON_DEC) begin
                                        nxt.tm.month = MON_JAN;
                                        if (i_cur.year < YEAR_MAX) begin
                                            nxt.tm.year = i_cur.year + 14'd1;
                                        end
                                    end else begin
                                        nxt.tm.month = i_cur.month + 4'd1;
                                    end
                                end else begin
                                    nxt.tm.day = i_cur.day + 5'd1;
                                end
                            end else begin
                                nxt.tm.hour = i_cur.hour + 5'd1;
                            end
                        end else begin
                            nxt.tm.min = i_cur.min + 6'd1;
                        end
                    end else begin
                        nxt.tm.sec = i_cur.sec + 6'd1;
                    end
                end else begin
                    nxt.prescale = i_prescale - 16'd1;
                end
            end
            CMD_LOAD: begin
                nxt.tm     = i_item.load;
                nxt.tm.day = (load_day == 5'd0) ? DAY_MIN : load_day;
            end
            default: begin
                case (i_item.sel)
                    FLD_SEC: begin
                        if (step_up) begin
                            nxt.tm.sec = (i_cur.sec >= SEC_MAX) ? 6'd0 : i_cur.sec + 6'd1;
                        end else begin
                            nxt.tm.sec = (i_cur.sec == 6'd0) ? SEC_MAX : i_cur.sec - 6'd1;
                        end
                    end
                    FLD_MIN: begin
                        if (step_up) begin
                            nxt.tm.min = (i_cur.min >= MIN_MAX) ? 6'd0 : i_cur.min + 6'd1;
                        end else begin
                            nxt.tm.min = (i_cur.min == 6'd0) ? MIN_MAX : i_cur.min - 6'd1;
                        end
                    end
                    FLD_HOUR: begin
                        if (step_up) begin
                            nxt.tm.hour = (i_cur.hour >= HOUR_MAX) ? 5'd0 : i_cur.hour + 5'd1;
                        end else begin
                            nxt.tm.hour = (i_cur.hour == 5'd0) ? HOUR_MAX : i_cur.hour - 5'd1;
                        end
                    end
                    FLD_DAY: begin
                        if (step_up) begin
                            nxt.tm.day = (i_cur.day >= cur_len) ? DAY_MIN : i_cur.day + 5'd1;
                        end else begin
                            nxt.tm.day = (i_cur.day <= DAY_MIN) ? cur_len : i_cur.day - 5'd1;
                        end
                    end
                    FLD_MONTH: begin
                        if (step_up) begin
                            nxt.tm.month = (i_cur.month >= MON_DEC) ? MON_JAN
                                                                    : i_cur.month + 4'd1;
                        end else begin
                            nxt.tm.month = (i_cur.month <= MON_JAN) ? MON_DEC
                                                                    : i_cur.month - 4'd1;
                        end
                    end
                    FLD_YEAR: begin
                        if (step_up) begin
                            if (i_cur.year < YEAR_MAX) begin
                                nxt.tm.year = i_cur.year + 14'd1;
                            end
                        end else begin
                            if (i_cur.year > YEAR_MIN) begin
                                nxt.tm.year = i_cur.year - 14'd1;
                            end
                        end
                    end
                    default: begin
                        nxt.tm = i_cur;
                    end
                endcase
            end
        endcase
    end

    assign o_next = nxt;

endmodule
